/* rtl/dqis_pkg.sv */
// Package with the types, codes and default sizes of the double-ended queue.
package dqis_pkg;

    localparam int DEFAULT_DEPTH      = 16;
    localparam int DEFAULT_DATA_WIDTH = 32;

    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int MIDX_W    = 4;
    localparam int COUNT_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_READ_AT    = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEARCH,
        S_DONE
    } state_t;

endpackage

/* rtl/dqis_ram.sv */
// Generic single-write, single-read memory with registered read data.
module dqis_ram #(
    parameter int WIDTH = dqis_pkg::DEFAULT_DATA_WIDTH,
    parameter int DEPTH = dqis_pkg::DEFAULT_DEPTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/deque_with_index_and_search.sv */
// Top level of the double-ended queue with indexed read and search.
//
// The queue holds up to DEPTH words of DATA_WIDTH bits in a ring buffer memory and takes one
// request at a time; req_stall is high after a beat is accepted until its result is
// loaded into the response register. Push and pop requests pass through an execute and a
// done state, a read at a position below the count adds a read state between the two, and
// a search adds a search state that runs until a match or the last element; every other
// request passes through execute and done only. The search walks the memory one element a
// cycle through its single read port and one comparator. A finished result waits in the
// response register while the next request is already being worked on.
module deque_with_index_and_search #(
    parameter int DEPTH      = dqis_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = dqis_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [dqis_pkg::OP_W-1:0]      operation,
    input  logic [dqis_pkg::VALUE_W-1:0]   value,
    input  logic [dqis_pkg::POS_W-1:0]     position,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [dqis_pkg::STATUS_W-1:0]  status,
    output logic [dqis_pkg::VALUE_W-1:0]   read_value,
    output logic                           match_found,
    output logic [dqis_pkg::MIDX_W-1:0]    match_index,
    output logic [dqis_pkg::COUNT_W-1:0]   count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int SUM_W = PTR_W + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > dqis_pkg::POS_W) ? CNT_W : dqis_pkg::POS_W;

    dqis_pkg::state_t  state_reg, state_next;
    dqis_pkg::op_t     op_reg, op_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [dqis_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [PTR_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  idx_reg, idx_next;
    dqis_pkg::status_t res_status_reg, res_status_next;
    logic [DATA_WIDTH-1:0] res_rdata_reg, res_rdata_next;
    logic              res_found_reg, res_found_next;

    logic              rsp_valid_reg, rsp_valid_next;
    dqis_pkg::status_t rsp_status_reg, rsp_status_next;
    logic [DATA_WIDTH-1:0] rsp_rdata_reg, rsp_rdata_next;
    logic              rsp_found_reg, rsp_found_next;
    logic [PTR_W-1:0]  rsp_idx_reg, rsp_idx_next;
    logic [CNT_W-1:0]  rsp_count_reg, rsp_count_next;

    logic [PTR_W-1:0]  offset;
    logic [SUM_W-1:0]  slot_sum;
    logic [PTR_W-1:0]  slot;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [DATA_WIDTH-1:0] ram_rd_data;
    logic              is_full;
    logic              is_empty;
    logic              rsp_free;
    logic              last_elem;

    // Shared address unit: slot of the element at an offset from the front.
    assign slot_sum = {1'b0, front_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= SUM_W'(DEPTH)) ? PTR_W'(slot_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(slot_sum);

    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign last_elem = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    dqis_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot),
        .wr_data (val_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (slot),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqis_pkg::S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_rdata_reg  <= res_rdata_next;
        res_found_reg  <= res_found_next;
        rsp_status_reg <= rsp_status_next;
        rsp_rdata_reg  <= rsp_rdata_next;
        rsp_found_reg  <= rsp_found_next;
        rsp_idx_reg    <= rsp_idx_next;
        rsp_count_reg  <= rsp_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_rdata_next  = res_rdata_reg;
        res_found_next  = res_found_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_status_next = rsp_status_reg;
        rsp_rdata_next  = rsp_rdata_reg;
        rsp_found_next  = rsp_found_reg;
        rsp_idx_next    = rsp_idx_reg;
        rsp_count_next  = rsp_count_reg;
        offset          = '0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        req_stall       = 1'b1;

        case (state_reg)
            dqis_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    op_next    = dqis_pkg::op_t'(operation);
                    val_next   = DATA_WIDTH'(value);
                    pos_next   = position;
                    state_next = dqis_pkg::S_EXEC;
                end
            end

            dqis_pkg::S_EXEC:
            begin
                res_status_next = dqis_pkg::ST_OK;
                res_rdata_next  = '0;
                res_found_next  = 1'b0;
                idx_next        = '0;
                state_next      = dqis_pkg::S_DONE;
                case (op_reg)
                    dqis_pkg::OP_PUSH_BACK:
                    begin
                        offset = PTR_W'(count_reg);
                        if (is_full)
                        begin
                            res_status_next = dqis_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_wr_en  = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    dqis_pkg::OP_PUSH_FRONT:
                    begin
                        offset = PTR_W'(DEPTH - 1);
                        if (is_full)
                        begin
                            res_status_next = dqis_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_wr_en  = 1'b1;
                            front_next = slot;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    dqis_pkg::OP_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = dqis_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    dqis_pkg::OP_POP_FRONT:
                    begin
                        offset = PTR_W'(1);
                        if (is_empty)
                        begin
                            res_status_next = dqis_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            front_next = slot;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    dqis_pkg::OP_SEARCH:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = dqis_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_rd_en  = 1'b1;
                            state_next = dqis_pkg::S_SEARCH;
                        end
                    end
                    dqis_pkg::OP_READ_AT:
                    begin
                        offset = PTR_W'(pos_reg);
                        if (CMP_W'(pos_reg) >= CMP_W'(count_reg))
                        begin
                            res_status_next = dqis_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ram_rd_en  = 1'b1;
                            state_next = dqis_pkg::S_READ;
                        end
                    end
                    default:
                    begin
                        res_status_next = dqis_pkg::ST_OK;
                    end
                endcase
            end

            dqis_pkg::S_READ:
            begin
                res_rdata_next = ram_rd_data;
                state_next     = dqis_pkg::S_DONE;
            end

            dqis_pkg::S_SEARCH:
            begin
                offset = idx_reg + PTR_W'(1);
                if (ram_rd_data == val_reg)
                begin
                    res_found_next = 1'b1;
                    state_next     = dqis_pkg::S_DONE;
                end
                else if (last_elem)
                begin
                    state_next = dqis_pkg::S_DONE;
                end
                else
                begin
                    ram_rd_en = 1'b1;
                    idx_next  = idx_reg + PTR_W'(1);
                end
            end

            dqis_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_rdata_next  = res_rdata_reg;
                    rsp_found_next  = res_found_reg;
                    rsp_idx_next    = res_found_reg ? idx_reg : '0;
                    rsp_count_next  = count_reg;
                    state_next      = dqis_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = dqis_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign read_value  = dqis_pkg::VALUE_W'(rsp_rdata_reg);
    assign match_found = rsp_found_reg;
    assign match_index = dqis_pkg::MIDX_W'(rsp_idx_reg);
    assign count       = dqis_pkg::COUNT_W'(rsp_count_reg);

    // The element count never goes beyond the capacity of the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
    else $error("element count exceeds capacity");

    // An accepted request beat always starts execution on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == dqis_pkg::S_EXEC))
    else $error("accepted request did not start execution");

    // The element count only changes as a request executes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == dqis_pkg::S_EXEC))
    else $error("element count changed outside execution");

    // A rejected push is only reported when the store is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg == dqis_pkg::ST_FULL))
            |-> (rsp_count_reg == CNT_W'(DEPTH)))
    else $error("full status reported with free space");

endmodule
